@@ design/rme_pkg.sv @@
// Shared types and constants for the register machine execute unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package rme_pkg;

    localparam int DATA_W             = 32;
    localparam int IDX_W              = 4;
    localparam int OPC_W              = 4;
    localparam int NEXT_PC_W          = 12;
    localparam int DEF_REGISTER_COUNT = 15;
    localparam int DEF_PROGRAM_DEPTH  = 4096;

    localparam logic [OPC_W-1:0] OP_ADD     = 4'd0;
    localparam logic [OPC_W-1:0] OP_MUL     = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB     = 4'd2;
    localparam logic [OPC_W-1:0] OP_DIV     = 4'd3;
    localparam logic [OPC_W-1:0] OP_COPY    = 4'd4;
    localparam logic [OPC_W-1:0] OP_LOADI   = 4'd5;
    localparam logic [OPC_W-1:0] OP_JUMP    = 4'd6;
    localparam logic [OPC_W-1:0] OP_JZ      = 4'd7;
    localparam logic [OPC_W-1:0] OP_LESS    = 4'd8;
    localparam logic [OPC_W-1:0] OP_GREATER = 4'd9;
    localparam logic [OPC_W-1:0] OP_EQUAL   = 4'd10;
    localparam logic [OPC_W-1:0] OP_PRINT   = 4'd11;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic [IDX_W-1:0]         dest_reg;
        logic [IDX_W-1:0]         src1_reg;
        logic [IDX_W-1:0]         src2_reg;
        logic signed [DATA_W-1:0] immediate;
    } rme_in_t;

    typedef struct packed {
        logic                     write_enable;
        logic signed [DATA_W-1:0] write_value;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic [NEXT_PC_W-1:0]     next_pc;
        logic                     divide_error;
    } rme_out_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } rf_rd_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ design/rme_regfile.sv @@
// Register file: synchronous memory with two registered read ports and one write port.
// Per-entry valid bits give the all-zero reset; depends on rme_pkg.
`default_nettype none

module rme_regfile #(
    parameter int REGISTER_COUNT = rme_pkg::DEF_REGISTER_COUNT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  rme_pkg::rf_rd_t                  rd_req,
    input  rme_pkg::rf_wr_t                  wr_req,
    output logic [rme_pkg::DATA_W-1:0]       rdata_a,
    output logic [rme_pkg::DATA_W-1:0]       rdata_b
);
    import rme_pkg::*;

    localparam int ADDR_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    logic [DATA_W-1:0]         mem_reg [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]         data_a_reg;
    logic [DATA_W-1:0]         data_b_reg;
    logic                      ok_a_reg;
    logic                      ok_b_reg;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_w;
    logic              in_a;
    logic              in_b;

    assign addr_a = ADDR_W'(rd_req.addr_a);
    assign addr_b = ADDR_W'(rd_req.addr_b);
    assign addr_w = ADDR_W'(wr_req.addr);
    assign in_a   = int'(rd_req.addr_a) < REGISTER_COUNT;
    assign in_b   = int'(rd_req.addr_b) < REGISTER_COUNT;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem_reg[addr_w] <= wr_req.data;
        end
        if (rd_req.en) begin
            data_a_reg <= mem_reg[addr_a];
            data_b_reg <= mem_reg[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            ok_a_reg <= 1'b0;
            ok_b_reg <= 1'b0;
        end else begin
            if (wr_req.en) begin
                vld_reg[addr_w] <= 1'b1;
            end
            if (rd_req.en) begin
                ok_a_reg <= in_a && vld_reg[addr_a];
                ok_b_reg <= in_b && vld_reg[addr_b];
            end
        end
    end

    assign rdata_a = ok_a_reg ? data_a_reg : '0;
    assign rdata_b = ok_b_reg ? data_b_reg : '0;

endmodule

`default_nettype wire

@@ design/rme_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of magnitudes; depends on rme_pkg.
`default_nettype none

module rme_divider (
    input  wire                aclk,
    input  wire                aresetn,
    input  rme_pkg::div_req_t  req,
    output rme_pkg::div_rsp_t  rsp
);
    import rme_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              run_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvs_reg;

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    logic            fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (req.start) begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                run_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign rsp.busy      = run_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/register_machine_execute_unit.sv @@
// Register machine execute unit: one instruction per input beat, one result beat each.
// Each result is registered in the execute state, except a divide by a nonzero register
// (and a taken jump when PROGRAM_DEPTH is not a power of two), whose result is registered
// in the divide state when the 32-step divider is done; both wait for a free output.
// One item in flight; a waiting result does not block the next input beat.
// Reset: synchronous active-low aresetn clears the register file and the pc to zero.
`default_nettype none

module register_machine_execute_unit #(
    parameter int REGISTER_COUNT = rme_pkg::DEF_REGISTER_COUNT,
    parameter int PROGRAM_DEPTH  = rme_pkg::DEF_PROGRAM_DEPTH
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  rme_pkg::rme_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output rme_pkg::rme_out_t m_data
);
    import rme_pkg::*;

    localparam int   PC_W    = $clog2(PROGRAM_DEPTH);
    localparam logic IS_POW2 = (PROGRAM_DEPTH & (PROGRAM_DEPTH - 1)) == 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    state_t            state_reg;
    rme_in_t           instr_reg;
    logic [PC_W-1:0]   pc_reg;
    logic              m_valid_reg;
    rme_out_t          m_data_reg;
    logic              neg_reg;
    logic              div_jump_reg;

    rf_rd_t            rd_req;
    rf_wr_t            wr_req;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              s_accept;
    logic              out_free;
    logic              dest_ok;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   imm_pc;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] quo_signed;
    logic              exec_need_div;
    logic              exec_jump_div;
    logic              wr;
    logic [DATA_W-1:0] val;
    logic [PC_W-1:0]   exec_pc;
    rme_out_t          exec_res;
    rme_out_t          div_res;
    logic [PC_W-1:0]   div_pc;
    logic              wb_go;
    rme_out_t          wb_res;
    logic [PC_W-1:0]   wb_pc;

    assign s_ready  = state_reg == ST_IDLE;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rd_req.en     = s_accept;
    assign rd_req.addr_a = (s_data.opcode == OP_JZ || s_data.opcode == OP_PRINT)
                           ? s_data.dest_reg : s_data.src1_reg;
    assign rd_req.addr_b = s_data.src2_reg;

    rme_regfile #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rdata_a (a),
        .rdata_b (b)
    );

    rme_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign dest_ok = int'(instr_reg.dest_reg) < REGISTER_COUNT;
    assign pc_inc  = (pc_reg == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign imm_pc  = instr_reg.immediate[PC_W-1:0];
    assign prod    = a * b;

    always_comb begin
        exec_need_div = 1'b0;
        exec_jump_div = 1'b0;
        wr            = 1'b0;
        val           = '0;
        exec_pc       = pc_inc;
        exec_res      = '0;
        unique case (instr_reg.opcode)
            OP_ADD: begin
                wr  = 1'b1;
                val = a + b;
            end
            OP_MUL: begin
                wr  = 1'b1;
                val = prod;
            end
            OP_SUB: begin
                wr  = 1'b1;
                val = a - b;
            end
            OP_DIV: begin
                if (b == '0) begin
                    exec_res.divide_error = 1'b1;
                end else begin
                    exec_need_div = 1'b1;
                end
            end
            OP_COPY: begin
                wr  = 1'b1;
                val = a;
            end
            OP_LOADI: begin
                wr  = 1'b1;
                val = instr_reg.immediate;
            end
            OP_JUMP: begin
                if (IS_POW2) begin
                    exec_pc = imm_pc;
                end else begin
                    exec_need_div = 1'b1;
                    exec_jump_div = 1'b1;
                end
            end
            OP_JZ: begin
                if (a == '0) begin
                    if (IS_POW2) begin
                        exec_pc = imm_pc;
                    end else begin
                        exec_need_div = 1'b1;
                        exec_jump_div = 1'b1;
                    end
                end
            end
            OP_LESS: begin
                wr  = 1'b1;
                val = DATA_W'($signed(a) < $signed(b));
            end
            OP_GREATER: begin
                wr  = 1'b1;
                val = DATA_W'($signed(b) < $signed(a));
            end
            OP_EQUAL: begin
                wr  = 1'b1;
                val = DATA_W'(a == b);
            end
            OP_PRINT: begin
                exec_res.print_valid = 1'b1;
                exec_res.print_value = a;
            end
            default: begin
            end
        endcase
        exec_res.write_enable = wr && dest_ok;
        exec_res.write_value  = (wr && dest_ok) ? val : '0;
        exec_res.next_pc      = NEXT_PC_W'(exec_pc);
    end

    always_comb begin
        div_req.start    = state_reg == ST_EXEC && exec_need_div;
        div_req.dividend = exec_jump_div ? instr_reg.immediate
                                         : (a[DATA_W-1] ? (~a + 1'b1) : a);
        div_req.divisor  = exec_jump_div ? DATA_W'(PROGRAM_DEPTH)
                                         : (b[DATA_W-1] ? (~b + 1'b1) : b);
    end

    assign quo_signed = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
    assign div_pc     = div_jump_reg ? PC_W'(div_rsp.remainder) : pc_inc;

    always_comb begin
        div_res              = '0;
        div_res.write_enable = !div_jump_reg && dest_ok;
        div_res.write_value  = (!div_jump_reg && dest_ok) ? quo_signed : '0;
        div_res.next_pc      = NEXT_PC_W'(div_pc);
    end

    always_comb begin
        wb_go  = 1'b0;
        wb_res = exec_res;
        wb_pc  = exec_pc;
        unique case (state_reg)
            ST_EXEC: begin
                wb_go = !exec_need_div && out_free;
            end
            ST_DIV: begin
                wb_go  = !div_rsp.busy && out_free;
                wb_res = div_res;
                wb_pc  = div_pc;
            end
            default: begin
            end
        endcase
    end

    assign wr_req.en   = wb_go && wb_res.write_enable;
    assign wr_req.addr = instr_reg.dest_reg;
    assign wr_req.data = wb_res.write_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_need_div) begin
                        state_reg <= ST_DIV;
                    end else if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (wb_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (wb_go) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= wb_pc;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            instr_reg <= s_data;
        end
        if (wb_go) begin
            m_data_reg <= wb_res;
        end
        if (div_req.start) begin
            neg_reg      <= a[DATA_W-1] ^ b[DATA_W-1];
            div_jump_reg <= exec_jump_div;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ design/rme_checker.sv @@
// Port-level checks for the register machine execute unit, bound to the top level.
// Depends on rme_pkg and register_machine_execute_unit.
`default_nettype none

module rme_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input rme_pkg::rme_in_t  s_data,
    input wire               m_valid,
    input wire               m_ready,
    input rme_pkg::rme_out_t m_data
);
    import rme_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an instruction is in flight");

    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.divide_error || m_data.print_valid) |->
            !m_data.write_enable && !(m_data.divide_error && m_data.print_valid))
        else $error("conflicting result flags");

endmodule

bind register_machine_execute_unit rme_checker u_rme_checker (.*);

`default_nettype wire
